FILE: sv/htok_pkg.sv
// ----------------------------------------------------------------------------
// htok_pkg
// Shared types and constants of the request head tokenizer: character codes,
// token kinds, event codes and the result beat layout.
// ----------------------------------------------------------------------------
`default_nettype none

package htok_pkg;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_COLON = 8'd58;

    localparam logic [2:0] TK_METHOD  = 3'd0;
    localparam logic [2:0] TK_URL     = 3'd1;
    localparam logic [2:0] TK_VERSION = 3'd2;
    localparam logic [2:0] TK_NAME    = 3'd3;
    localparam logic [2:0] TK_VALUE   = 3'd4;
    localparam logic [2:0] TK_NONE    = 3'd0;

    localparam logic [2:0] EV_TOKEN_END   = 3'd0;
    localparam logic [2:0] EV_HDR_ACCEPT  = 3'd1;
    localparam logic [2:0] EV_HDR_REJECT  = 3'd2;
    localparam logic [2:0] EV_REQ_DONE    = 3'd3;
    localparam logic [2:0] EV_MALFORMED   = 3'd4;

    localparam logic PHASE_REQ = 1'b0;
    localparam logic PHASE_HDR = 1'b1;

    localparam logic [1:0] FIELD_METHOD  = 2'd0;
    localparam logic [1:0] FIELD_VERSION = 2'd2;

    typedef struct packed {
        logic [2:0] token_kind;
        logic       is_data;
        logic [7:0] data_byte;
        logic [2:0] event_code;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        logic       phase;
        logic [1:0] line_field;
        logic       held_cr;
        logic       held_colon;
        logic       in_value;
        logic       name_nonempty;
        logic       value_nonempty;
        logic       line_nonempty;
    } parse_state_t;

endpackage

`default_nettype wire

FILE: sv/http_request_head_tokenizer.sv
// ----------------------------------------------------------------------------
// http_request_head_tokenizer
// Splits an HTTP request head into tagged token bytes and marker events.
// ----------------------------------------------------------------------------
// One request byte is taken per cycle while s_ready is high. Each byte
// yields zero, one or two result beats, computed in the accept cycle and
// written into a 4-entry result queue that registers them for output.
// s_ready is high whenever the queue has at least two free entries, so with
// m_ready held high a byte is taken every cycle; line ends and released CR
// or colon bytes can add a second beat, which the queue absorbs.
`default_nettype none

module http_request_head_tokenizer (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [7:0]          s_in_byte,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [2:0]          m_token_kind,
    output logic                m_is_data,
    output logic [7:0]          m_data_byte,
    output logic [2:0]          m_event_code,
    output logic                m_last_of_run
);
    import htok_pkg::*;

    localparam int QDEPTH = 4;

    parse_state_t state_reg, state_next;
    result_t      res [2];
    logic [1:0]   n_res;

    result_t      q_reg [QDEPTH];
    logic [1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [2:0]   cnt_reg, cnt_next;
    logic         push, pop;

    function automatic result_t mk(input logic [2:0] kind, input logic isdata,
                                   input logic [7:0] b, input logic [2:0] ev);
        result_t r;
        r.token_kind  = kind;
        r.is_data     = isdata;
        r.data_byte   = b;
        r.event_code  = ev;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    function automatic logic [2:0] cur_kind(input parse_state_t s);
        logic [2:0] k;
        if (s.phase == PHASE_REQ) begin
            k = {1'b0, s.line_field};
        end else begin
            k = s.in_value ? TK_VALUE : TK_NAME;
        end
        return k;
    endfunction

    // next parse state and the beats this byte produces
    always_comb begin
        parse_state_t s;
        logic         do_plain;
        s        = state_reg;
        do_plain = 1'b0;
        n_res    = 2'd0;
        res[0]   = '0;
        res[1]   = '0;

        if (s.held_cr) begin
            s.held_cr = 1'b0;
            if (s_in_byte == CH_LF) begin
                // end of line
                if (s.phase == PHASE_REQ) begin
                    if (s.line_nonempty) begin
                        res[n_res[0]] = mk({1'b0, s.line_field}, 1'b0, 8'd0,
                                           EV_TOKEN_END);
                        n_res = n_res + 2'd1;
                        if (s.line_field < FIELD_VERSION) begin
                            res[n_res[0]] = mk(TK_NONE, 1'b0, 8'd0, EV_MALFORMED);
                            n_res = n_res + 2'd1;
                        end
                        s.phase = PHASE_HDR;
                    end
                end else if (!s.line_nonempty) begin
                    res[n_res[0]] = mk(TK_NONE, 1'b0, 8'd0, EV_REQ_DONE);
                    n_res = n_res + 2'd1;
                    s.phase = PHASE_REQ;
                end else if (s.in_value) begin
                    res[n_res[0]] = mk(TK_VALUE, 1'b0, 8'd0, EV_TOKEN_END);
                    n_res = n_res + 2'd1;
                    res[n_res[0]] = mk(TK_NONE, 1'b0, 8'd0,
                        (s.name_nonempty && s.value_nonempty) ? EV_HDR_ACCEPT
                                                              : EV_HDR_REJECT);
                    n_res = n_res + 2'd1;
                end else begin
                    res[n_res[0]] = mk(TK_NAME, 1'b0, 8'd0, EV_TOKEN_END);
                    n_res = n_res + 2'd1;
                    res[n_res[0]] = mk(TK_NONE, 1'b0, 8'd0, EV_HDR_REJECT);
                    n_res = n_res + 2'd1;
                end
                if (s.phase != state_reg.phase || s.phase == PHASE_HDR) begin
                    s.line_field = FIELD_METHOD;
                end
                if (s.phase != state_reg.phase) begin
                    s.line_field = FIELD_METHOD;
                end
                s.held_colon     = 1'b0;
                s.in_value       = 1'b0;
                s.name_nonempty  = 1'b0;
                s.value_nonempty = 1'b0;
                s.line_nonempty  = 1'b0;
            end else begin
                // release the held cr as data
                s.line_nonempty = 1'b1;
                res[n_res[0]] = mk(cur_kind(s), 1'b1, CH_CR, EV_TOKEN_END);
                n_res = n_res + 2'd1;
                if (s.phase == PHASE_HDR) begin
                    if (s.in_value) s.value_nonempty = 1'b1;
                    else            s.name_nonempty  = 1'b1;
                end
                do_plain = 1'b1;
            end
        end else if (s.held_colon) begin
            s.held_colon = 1'b0;
            if (s_in_byte == CH_SP) begin
                res[n_res[0]] = mk(TK_NAME, 1'b0, 8'd0, EV_TOKEN_END);
                n_res = n_res + 2'd1;
                s.in_value = 1'b1;
            end else begin
                res[n_res[0]] = mk(cur_kind(s), 1'b1, CH_COLON, EV_TOKEN_END);
                n_res = n_res + 2'd1;
                if (s.phase == PHASE_HDR) begin
                    if (s.in_value) s.value_nonempty = 1'b1;
                    else            s.name_nonempty  = 1'b1;
                end
                do_plain = 1'b1;
            end
        end else begin
            do_plain = 1'b1;
        end

        if (do_plain) begin
            if (s_in_byte == CH_CR) begin
                s.held_cr = 1'b1;
            end else begin
                s.line_nonempty = 1'b1;
                if (s.phase == PHASE_REQ && s_in_byte == CH_SP
                        && s.line_field < FIELD_VERSION) begin
                    res[n_res[0]] = mk({1'b0, s.line_field}, 1'b0, 8'd0,
                                       EV_TOKEN_END);
                    n_res = n_res + 2'd1;
                    s.line_field = s.line_field + 2'd1;
                end else if (s.phase == PHASE_HDR && s_in_byte == CH_COLON
                        && !s.in_value) begin
                    s.held_colon = 1'b1;
                end else begin
                    res[n_res[0]] = mk(cur_kind(s), 1'b1, s_in_byte, EV_TOKEN_END);
                    n_res = n_res + 2'd1;
                    if (s.phase == PHASE_HDR) begin
                        if (s.in_value) s.value_nonempty = 1'b1;
                        else            s.name_nonempty  = 1'b1;
                    end
                end
            end
        end

        if (n_res == 2'd1) res[0].last_of_run = 1'b1;
        if (n_res == 2'd2) res[1].last_of_run = 1'b1;
        state_next = s;
    end

    assign s_ready  = (cnt_reg <= 3'(QDEPTH - 2));
    assign push     = s_valid && s_ready;
    assign m_valid  = (cnt_reg != 3'd0);
    assign pop      = m_valid && m_ready;
    assign cnt_next = cnt_reg + (push ? {1'b0, n_res} : 3'd0) - {2'b00, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                state_reg  <= state_next;
                wr_ptr_reg <= wr_ptr_reg + n_res;
            end
            if (pop) rd_ptr_reg <= rd_ptr_reg + 2'd1;
            cnt_reg <= cnt_next;
        end
    end

    // result queue payload
    always_ff @(posedge aclk) begin
        if (push && n_res != 2'd0) q_reg[wr_ptr_reg] <= res[0];
        if (push && n_res == 2'd2) q_reg[wr_ptr_reg + 2'd1] <= res[1];
    end

    assign m_token_kind  = q_reg[rd_ptr_reg].token_kind;
    assign m_is_data     = q_reg[rd_ptr_reg].is_data;
    assign m_data_byte   = q_reg[rd_ptr_reg].data_byte;
    assign m_event_code  = q_reg[rd_ptr_reg].event_code;
    assign m_last_of_run = q_reg[rd_ptr_reg].last_of_run;

endmodule

`default_nettype wire

FILE: sv/htok_checker.sv
// ----------------------------------------------------------------------------
// htok_checker
// Port-level checks of the request head tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module htok_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       m_valid,
    input wire       m_ready,
    input wire [2:0] m_token_kind,
    input wire       m_is_data,
    input wire [2:0] m_event_code,
    input wire       m_last_of_run
);
    import htok_pkg::*;

    // no beat right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    // a stalled beat stays
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // data beats carry a token kind in range and no event
    a_data_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_data |-> m_token_kind <= TK_VALUE
                                 && m_event_code == EV_TOKEN_END)
        else $error("bad data beat");

    // line events close the run of their byte and carry no token kind
    a_event_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_data && m_event_code != EV_TOKEN_END
            |-> m_last_of_run && m_token_kind == TK_NONE
                && m_event_code <= EV_MALFORMED)
        else $error("bad line event beat");

endmodule

bind http_request_head_tokenizer htok_checker u_htok_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_token_kind  (m_token_kind),
    .m_is_data     (m_is_data),
    .m_event_code  (m_event_code),
    .m_last_of_run (m_last_of_run)
);

`default_nettype wire

FILE: tb/tb_http_request_head_tokenizer.sv
// ----------------------------------------------------------------------------
// tb_http_request_head_tokenizer
// Self-checking bench for the HTTP request head tokenizer. A short fixed byte
// stream covers the corner cases: skipped blank lines, extreme byte values,
// extra spaces, lone CR and LF, colons, rejected headers and a malformed
// request line. It is followed by random request heads with some noise.
// Each accepted byte is run through a cycle-free model of the tokenizer. The
// predicted beats are queued and compared field by field with the result
// channel, while both sides stall at random.
// ----------------------------------------------------------------------------
module tb_http_request_head_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import htok_pkg::*;

    localparam int         OPENING_LEN  = 27;
    localparam int         RANDOM_BYTES = 190;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 20;
    localparam logic [2:0] EV_NONE      = 3'd0;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [2:0]  m_token_kind;
    logic        m_is_data;
    logic [7:0]  m_data_byte;
    logic [2:0]  m_event_code;
    logic        m_last_of_run;

    logic [7:0]  head_bytes[$];
    logic [7:0]  opening_seq[OPENING_LEN];
    result_t     awaited_beats[$];
    result_t     step_beats[$];

    // tokenizer model state
    logic        ph;
    logic [1:0]  fld;
    logic        cr_held;
    logic        colon_held;
    logic        in_val;
    logic        name_seen;
    logic        val_seen;
    logic        line_seen;

    int          bytes_taken = 0;
    int          cycle_cnt = 0;
    int          mismatches = 0;
    int          beats_checked = 0;
    int          reqs_done = 0;
    int          hdrs_ok = 0;
    int          hdrs_bad = 0;
    int          bad_lines = 0;
    logic        calm;
    logic        fire;
    result_t     want;

    http_request_head_tokenizer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_is_data     (m_is_data),
        .m_data_byte   (m_data_byte),
        .m_event_code  (m_event_code),
        .m_last_of_run (m_last_of_run)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // no stalls on either side in this stretch
    assign calm = (bytes_taken >= 90) && (bytes_taken < 170);

    function automatic void push_beat(logic [2:0] kind, logic isd, logic [7:0] b,
                                      logic [2:0] ev);
        result_t r;
        if (step_beats.size() >= 3) return;
        r.token_kind  = kind;
        r.is_data     = isd;
        r.data_byte   = b;
        r.event_code  = ev;
        r.last_of_run = 1'b0;
        step_beats.push_back(r);
    endfunction

    function automatic logic [2:0] token_now();
        if (ph == PHASE_REQ) return {1'b0, fld};
        return in_val ? TK_VALUE : TK_NAME;
    endfunction

    function automatic void push_token_byte(logic [7:0] b);
        push_beat(token_now(), 1'b1, b, EV_NONE);
        if (ph == PHASE_HDR) begin
            if (in_val) val_seen = 1'b1;
            else name_seen = 1'b1;
        end
    endfunction

    function automatic void clear_line_flags();
        cr_held    = 1'b0;
        colon_held = 1'b0;
        in_val     = 1'b0;
        name_seen  = 1'b0;
        val_seen   = 1'b0;
        line_seen  = 1'b0;
    endfunction

    function automatic void take_plain(logic [7:0] b);
        if (b == CH_CR) begin
            cr_held = 1'b1;
            return;
        end
        line_seen = 1'b1;
        if (ph == PHASE_REQ) begin
            if (b == CH_SP && fld < FIELD_VERSION) begin
                push_beat({1'b0, fld}, 1'b0, 8'h00, EV_TOKEN_END);
                fld = fld + 2'd1;
            end else begin
                push_token_byte(b);
            end
        end else if (b == CH_COLON && !in_val) begin
            colon_held = 1'b1;
        end else begin
            push_token_byte(b);
        end
    endfunction

    function automatic void tokenize_byte(logic [7:0] b);
        step_beats.delete();
        if (cr_held) begin
            cr_held = 1'b0;
            if (b == CH_LF) begin
                if (ph == PHASE_REQ) begin
                    // blank lines ahead of the request line are dropped
                    if (line_seen) begin
                        push_beat({1'b0, fld}, 1'b0, 8'h00, EV_TOKEN_END);
                        if (fld < FIELD_VERSION) push_beat(TK_NONE, 1'b0, 8'h00, EV_MALFORMED);
                        ph  = PHASE_HDR;
                        fld = FIELD_METHOD;
                    end
                end else if (!line_seen) begin
                    push_beat(TK_NONE, 1'b0, 8'h00, EV_REQ_DONE);
                    ph  = PHASE_REQ;
                    fld = FIELD_METHOD;
                end else if (in_val) begin
                    push_beat(TK_VALUE, 1'b0, 8'h00, EV_TOKEN_END);
                    push_beat(TK_NONE, 1'b0, 8'h00,
                              (name_seen && val_seen) ? EV_HDR_ACCEPT : EV_HDR_REJECT);
                end else begin
                    push_beat(TK_NAME, 1'b0, 8'h00, EV_TOKEN_END);
                    push_beat(TK_NONE, 1'b0, 8'h00, EV_HDR_REJECT);
                end
                clear_line_flags();
            end else begin
                line_seen = 1'b1;
                push_token_byte(CH_CR);
                take_plain(b);
            end
        end else if (colon_held) begin
            colon_held = 1'b0;
            if (b == CH_SP) begin
                push_beat(TK_NAME, 1'b0, 8'h00, EV_TOKEN_END);
                in_val = 1'b1;
            end else begin
                push_token_byte(CH_COLON);
                take_plain(b);
            end
        end else begin
            take_plain(b);
        end
        if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last_of_run = 1'b1;
        foreach (step_beats[i]) awaited_beats.push_back(step_beats[i]);
    endfunction

    function automatic void add_byte(logic [7:0] b);
        head_bytes.push_back(b);
    endfunction

    function automatic logic [7:0] rand_text_byte(bit no_sp, bit no_colon);
        logic [7:0] b;
        if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(97, 122));
        else b = 8'($urandom_range(0, 255));
        if (b == CH_CR || (no_sp && b == CH_SP) || (no_colon && b == CH_COLON)) b = "x";
        return b;
    endfunction

    function automatic void add_text(int n, bit no_sp, bit no_colon);
        repeat (n) add_byte(rand_text_byte(no_sp, no_colon));
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 4))
            0: return CH_CR;
            1: return CH_LF;
            2: return CH_SP;
            3: return CH_COLON;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_line_end();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endfunction

    function automatic void add_request();
        int shape;
        int kind;
        shape = $urandom_range(0, 99);
        if (shape < 10) begin
            repeat ($urandom_range(3, 8)) add_byte(noise_byte());
            return;
        end
        if ($urandom_range(0, 4) == 0) add_line_end();
        add_text($urandom_range(0, 3), 1'b1, 1'b0);
        if (shape < 18) begin
            // request line with fewer than two spaces
            if ($urandom_range(0, 1) == 1) begin
                add_byte(CH_SP);
                add_text($urandom_range(0, 3), 1'b1, 1'b0);
            end
        end else begin
            add_byte(CH_SP);
            add_text($urandom_range(0, 3), 1'b1, 1'b0);
            add_byte(CH_SP);
            add_text($urandom_range(1, 3), 1'b0, 1'b0);
        end
        add_line_end();
        repeat ($urandom_range(0, 3)) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                add_text($urandom_range(1, 4), 1'b0, 1'b1);
            end else begin
                if (kind != 1) add_text($urandom_range(1, 3), 1'b0, 1'b1);
                add_byte(CH_COLON);
                add_byte(CH_SP);
                if (kind != 2) add_text($urandom_range(1, 4), 1'b0, 1'b0);
            end
            add_line_end();
        end
        add_line_end();
    endfunction

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // request byte driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            fire = s_valid && s_ready;
            if (fire) begin
                tokenize_byte(s_in_byte);
                bytes_taken <= bytes_taken + 1;
            end
            if (!s_valid || fire) begin
                if (head_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 24)) begin
                    s_in_byte <= head_bytes.pop_front();
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result beat monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_beats.size() == 0) begin
                    $error("unexpected beat: token_kind %0d is_data %0d data_byte %02h event_code %0d",
                           m_token_kind, m_is_data, m_data_byte, m_event_code);
                    mismatches++;
                end else begin
                    want = awaited_beats.pop_front();
                    beats_checked++;
                    if (m_token_kind !== want.token_kind) begin
                        $error("token_kind: expected %0d, got %0d", want.token_kind, m_token_kind);
                        mismatches++;
                    end
                    if (m_is_data !== want.is_data) begin
                        $error("is_data: expected %0d, got %0d", want.is_data, m_is_data);
                        mismatches++;
                    end
                    if (m_data_byte !== want.data_byte) begin
                        $error("data_byte: expected %02h, got %02h", want.data_byte, m_data_byte);
                        mismatches++;
                    end
                    if (m_event_code !== want.event_code) begin
                        $error("event_code: expected %0d, got %0d", want.event_code, m_event_code);
                        mismatches++;
                    end
                    if (m_last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0d, got %0d",
                               want.last_of_run, m_last_of_run);
                        mismatches++;
                    end
                    if (!want.is_data) begin
                        case (want.event_code)
                            EV_REQ_DONE:   reqs_done++;
                            EV_HDR_ACCEPT: hdrs_ok++;
                            EV_HDR_REJECT: hdrs_bad++;
                            EV_MALFORMED:  bad_lines++;
                            default: ;
                        endcase
                    end
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 24);
        end
    end

    initial begin
        ph  = PHASE_REQ;
        fld = FIELD_METHOD;
        clear_line_flags();

        // blank line, extreme bytes with a third space, empty-name header with
        // lone cr and lf, header without colon-space, end of head, short line
        opening_seq = '{CH_CR, CH_LF,
                        8'h00, CH_SP, 8'hFF, CH_SP, "V", CH_SP, CH_CR, CH_LF,
                        CH_COLON, CH_SP, CH_CR, "q", CH_LF, CH_CR, CH_LF,
                        "n", CH_COLON, "x", CH_CR, CH_LF,
                        CH_CR, CH_LF,
                        "G", CH_CR, CH_LF};
        foreach (opening_seq[i]) add_byte(opening_seq[i]);
        while (head_bytes.size() < OPENING_LEN + RANDOM_BYTES) add_request();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (head_bytes.size() > 0 || s_valid || awaited_beats.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (awaited_beats.size() != 0) begin
            $error("%0d expected beats never arrived", awaited_beats.size());
            mismatches++;
        end
        $display("Covered %0d request bytes and %0d result beats", bytes_taken, beats_checked);
        $display("Events: %0d heads done, %0d headers accepted, %0d rejected, %0d malformed",
                 reqs_done, hdrs_ok, hdrs_bad, bad_lines);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/htok_pkg.sv
sv/http_request_head_tokenizer.sv
sv/htok_checker.sv
tb/tb_http_request_head_tokenizer.sv
